>>> sv/piea_pkg.sv
// ----------------------------------------------------------------------------
// piea_pkg
// Shared constants, codes and the command bundle of the insert/erase array.
// ----------------------------------------------------------------------------
package piea_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_ERASE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // broadcast to every cell; ins/era only set for a transaction that succeeds
  typedef struct packed {
    logic                 ins;
    logic                 era;
    logic [CNT_W-1:0]     pos;
    logic [WORD_BITS-1:0] value;
  } cell_cmd_t;

endpackage

>>> sv/piea_cell.sv
// ----------------------------------------------------------------------------
// piea_cell
// One list entry: holds, loads the new word, or takes a neighbour's word.
// ----------------------------------------------------------------------------
module piea_cell (
  input  logic                           clk_i,
  input  logic [piea_pkg::IDX_W-1:0]     idx_i,    // fixed place in the row
  input  piea_pkg::cell_cmd_t            cmd_i,
  input  logic [piea_pkg::WORD_BITS-1:0] left_i,   // entry idx-1
  input  logic [piea_pkg::WORD_BITS-1:0] right_i,  // entry idx+1
  output logic [piea_pkg::WORD_BITS-1:0] data_o
);

  logic [piea_pkg::WORD_BITS-1:0] data_q, data_d;
  logic [piea_pkg::CNT_W-1:0]     idx_ext;

  assign idx_ext = piea_pkg::CNT_W'(idx_i);

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (idx_ext > cmd_i.pos) begin
        data_d = left_i;
      end else if (idx_ext == cmd_i.pos) begin
        data_d = cmd_i.value;
      end
    end else if (cmd_i.era && (idx_ext >= cmd_i.pos)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> sv/positional_insert_erase_array.sv
// Output: the result of each accepted transaction is held in the output register.
// Throughput: one transaction per cycle while the result side takes results;
// every cell shifts in the same cycle, so the row of entry cells sets the rate,
// not the list length.
// Reset: asynchronous, active low; clears the entry count and output valid.
// ----------------------------------------------------------------------------
// positional_insert_erase_array
// Ordered list of signed words held packed from entry 0 in a row of cells.
// Insert places a word at a position and moves later entries up; erase
// takes out the entry at a position and moves later entries down.
// ----------------------------------------------------------------------------
module positional_insert_erase_array (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [4:0] position, [36:5] value, rest zero
  input  logic [0:0]  s_axis_tuser,   // [0] opcode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] removed_value, [36:32] count_after
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int CW = piea_pkg::CNT_W;
  localparam int WB = piea_pkg::WORD_BITS;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic          in_op;
  logic [CW-1:0] in_pos;
  logic [WB-1:0] in_value;
  logic          s_fire;

  assign in_op    = s_axis_tuser[0];
  assign in_pos   = s_axis_tdata[CW-1:0];
  // 32-bit value field, sign-extended to the stored word width
  assign in_value = WB'($signed(s_axis_tdata[CW +: 32]));

  // Output register parts the two sides: a new transaction is taken whenever
  // the held result leaves in the same cycle or none is held.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Entry count and result classification
  // --------------------------------------------------------------------------
  logic [CW-1:0] count_q, count_d;
  logic [1:0]    status;
  logic          ins_ok, era_ok;
  logic          is_full;

  assign is_full = (count_q == CW'(piea_pkg::DEPTH));

  always_comb begin
    status = piea_pkg::ST_OK;
    ins_ok = 1'b0;
    era_ok = 1'b0;
    if (in_op == piea_pkg::OP_INSERT) begin
      // position check takes precedence over the full check
      if (in_pos > count_q) begin
        status = piea_pkg::ST_BAD_POS;
      end else if (is_full) begin
        status = piea_pkg::ST_FULL;
      end else begin
        ins_ok = 1'b1;
      end
    end else begin
      if (count_q == '0) begin
        status = piea_pkg::ST_EMPTY;
      end else if (in_pos >= count_q) begin
        status = piea_pkg::ST_BAD_POS;
      end else begin
        era_ok = 1'b1;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (s_fire && ins_ok) begin
      count_d = count_q + CW'(1);
    end else if (s_fire && era_ok) begin
      count_d = count_q - CW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Row of cells: each entry sees both neighbours, the ends see zero
  // --------------------------------------------------------------------------
  piea_pkg::cell_cmd_t cmd;
  logic [WB-1:0]       entry_w [piea_pkg::DEPTH];

  assign cmd.ins   = s_fire && ins_ok;
  assign cmd.era   = s_fire && era_ok;
  assign cmd.pos   = in_pos;
  assign cmd.value = in_value;

  for (genvar g = 0; g < piea_pkg::DEPTH; g++) begin : g_cell
    logic [WB-1:0] left_w, right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end

    if (g == piea_pkg::DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end

    piea_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (piea_pkg::IDX_W'(g)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (entry_w[g])
    );
  end

  // Word taken out by an erase: position is below the count, hence in range.
  logic [WB-1:0] removed;

  assign removed = era_ok ? entry_w[in_pos[piea_pkg::IDX_W-1:0]] : '0;

  // --------------------------------------------------------------------------
  // Count and output register
  // --------------------------------------------------------------------------
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_removed_q;
  logic [1:0]    out_status_q;
  logic [CW-1:0] out_count_q;

  assign out_valid_d = s_fire || (m_axis_tvalid && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_removed_q <= removed[31:0];
      out_status_q  <= status;
      out_count_q   <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_count_q, out_removed_q};
  assign m_axis_tuser  = out_status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(piea_pkg::DEPTH))
    else $error("entry count beyond capacity");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && ins_ok) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("successful insert did not grow the list");

  a_empty_erase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (in_op == piea_pkg::OP_ERASE) && (count_q == '0)) |=>
      (m_axis_tvalid && (m_axis_tuser == piea_pkg::ST_EMPTY) &&
       (m_axis_tdata[31:0] == 32'd0) && (count_q == '0)))
    else $error("erase on empty list not reported as such");
`endif

endmodule

>>> test/tb_positional_insert_erase_array.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_insert_erase_array
// Streams insert and erase transactions into the ordered list. A shadow list
// of words predicts each result. The monitor checks removed value, status and
// count against the oldest prediction. Both stream sides idle at random, and
// the result side holds off once for a long time so that the input stalls.
// ----------------------------------------------------------------------------
module tb_positional_insert_erase_array;

  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned LONG_HOLD    = 200;  // cycles of the one long result stall

  typedef struct packed {
    logic                       op;
    logic [piea_pkg::CNT_W-1:0] pos;
    logic [31:0]                val;
  } list_cmd_t;

  typedef struct {
    logic [31:0]                removed;
    logic [1:0]                 status;
    logic [piea_pkg::CNT_W-1:0] count;
    int unsigned                stamp;    // cycle in which the transaction was accepted
  } list_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // [4:0] position, [36:5] value, rest zero
  logic [0:0]  s_axis_tuser  = '0;   // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // [31:0] removed_value, [36:32] count_after
  logic [1:0]  m_axis_tuser;         // [1:0] status

  list_cmd_t    pending_q[$];
  list_result_t expected_q[$];

  // shadow of the list contents
  logic [piea_pkg::WORD_BITS-1:0] shadow_words[piea_pkg::DEPTH];
  int unsigned                    shadow_len = 0;

  int unsigned stim_len     = 0;     // list length as seen while building stimulus
  int unsigned cycle_no     = 0;
  int unsigned n_items      = 0;
  int unsigned n_accepted   = 0;
  int unsigned n_results    = 0;
  int unsigned n_errors     = 0;
  int unsigned n_inserts    = 0;
  int unsigned status_hits[4];

  int unsigned send_gap   = 0;
  int unsigned send_calm  = 0;
  int unsigned recv_gap   = 0;
  int unsigned recv_calm  = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;

  positional_insert_erase_array i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_no <= cycle_no + 1;

  // mostly short idles, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Applies one transaction to the shadow list and returns what the block
  // should answer.
  function automatic list_result_t apply_to_list(list_cmd_t c, int unsigned stamp);
    list_result_t r;
    r.removed = '0;
    r.status  = piea_pkg::ST_OK;
    r.stamp   = stamp;
    if (c.op == piea_pkg::OP_INSERT) begin
      if (c.pos > shadow_len) begin
        r.status = piea_pkg::ST_BAD_POS;
      end else if (shadow_len >= piea_pkg::DEPTH) begin
        r.status = piea_pkg::ST_FULL;
      end else begin
        for (int k = shadow_len; k > c.pos; k--) shadow_words[k] = shadow_words[k-1];
        shadow_words[c.pos] = piea_pkg::WORD_BITS'($signed(c.val));
        shadow_len++;
      end
    end else begin
      if (shadow_len == 0) begin
        r.status = piea_pkg::ST_EMPTY;
      end else if (c.pos >= shadow_len) begin
        r.status = piea_pkg::ST_BAD_POS;
      end else begin
        r.removed = shadow_words[c.pos][31:0];
        for (int k = c.pos; k + 1 < shadow_len; k++) shadow_words[k] = shadow_words[k+1];
        shadow_len--;
      end
    end
    r.count = piea_pkg::CNT_W'(shadow_len);
    return r;
  endfunction

  // Queues a transaction; only the list length is tracked here, so that
  // random positions can be aimed at the valid range.
  task automatic queue_cmd(input logic op, input int unsigned pos, input logic [31:0] val);
    list_cmd_t c;
    c.op  = op;
    c.pos = piea_pkg::CNT_W'(pos);
    c.val = val;
    pending_q.push_back(c);
    if (op == piea_pkg::OP_INSERT) begin
      if (c.pos <= stim_len && stim_len < piea_pkg::DEPTH) stim_len++;
    end else if (stim_len != 0 && c.pos < stim_len) begin
      stim_len--;
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Driver: takes the next pending transaction once the bus is free.
  always @(posedge clk_i) begin : drive_proc
    list_cmd_t c;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        c.op  = s_axis_tuser[0];
        c.pos = s_axis_tdata[4:0];
        c.val = s_axis_tdata[36:5];
        expected_q.push_back(apply_to_list(c, cycle_no));
        if (c.op == piea_pkg::OP_INSERT) n_inserts++;
        n_accepted <= n_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          c = pending_q.pop_front();
          s_axis_tdata  <= {3'b000, c.val, c.pos};
          s_axis_tuser  <= c.op;
          s_axis_tvalid <= 1'b1;
          if (send_calm != 0) begin
            send_calm--;
            send_gap <= 0;
          end else begin
            if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(20, 60);
            send_gap <= ($urandom_range(0, 99) < 60) ? 0 : idle_len();
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side ready: random stalls, calm stretches and one long hold-off
  // part way through so that the block fills and pushes back on its input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && n_results >= 400) begin
        hold_done     <= 1'b1;
        hold_left     <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap      <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_calm != 0) begin
        recv_calm     <= recv_calm - 1;
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < 2) begin
          recv_calm <= $urandom_range(30, 80);
        end else if ($urandom_range(0, 99) < 20) begin
          recv_gap <= idle_len();
        end
      end
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    n_errors++;
  endtask

  // Monitor: every result transaction against the oldest prediction.
  always @(posedge clk_i) begin : check_proc
    list_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results <= n_results + 1;
      // a prediction made at this very edge cannot own this result
      if (expected_q.size() == 0 || expected_q[0].stamp == cycle_no) begin
        $display("%0t: result with nothing expected, actual removed %0h status %0d count %0d",
                 $time, m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[36:32]);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        status_hits[e.status]++;
        if (m_axis_tdata[31:0] !== e.removed)
          report_mismatch("removed_value", e.removed, m_axis_tdata[31:0]);
        if (m_axis_tuser !== e.status)
          report_mismatch("status", 32'(e.status), 32'(m_axis_tuser));
        if (m_axis_tdata[36:32] !== e.count)
          report_mismatch("count_after", 32'(e.count), 32'(m_axis_tdata[36:32]));
      end
    end
  end

  initial begin : stimulus_proc
    int unsigned ins_bias;
    int unsigned drain;
    logic        op;

    foreach (status_hits[i]) status_hits[i] = 0;

    // directed: empty list, extreme values, head/tail/middle, full list
    queue_cmd(piea_pkg::OP_ERASE,  0,  32'h0);          // erase on empty list
    queue_cmd(piea_pkg::OP_ERASE,  31, 32'hFFFF_FFFF);  // erase on empty, all position bits set
    queue_cmd(piea_pkg::OP_INSERT, 1,  32'h1234_5678);  // insert beyond count
    queue_cmd(piea_pkg::OP_INSERT, 0,  32'h8000_0000);
    queue_cmd(piea_pkg::OP_INSERT, 1,  32'h7FFF_FFFF);  // at tail
    queue_cmd(piea_pkg::OP_INSERT, 0,  32'hFFFF_FFFF);  // at head
    queue_cmd(piea_pkg::OP_INSERT, 1,  32'h0000_0000);  // in the middle
    queue_cmd(piea_pkg::OP_ERASE,  4,  32'h0);          // erase at count
    queue_cmd(piea_pkg::OP_ERASE,  31, 32'h0);          // erase far beyond count
    queue_cmd(piea_pkg::OP_INSERT, 31, 32'h5555_5555);  // insert far beyond count
    while (stim_len < piea_pkg::DEPTH)
      queue_cmd(piea_pkg::OP_INSERT, $urandom_range(0, stim_len), $urandom());
    queue_cmd(piea_pkg::OP_INSERT, piea_pkg::DEPTH,     32'hAAAA_AAAA); // full list
    queue_cmd(piea_pkg::OP_INSERT, piea_pkg::DEPTH + 1, 32'hAAAA_AAAA); // position check wins
    queue_cmd(piea_pkg::OP_INSERT, 0,                   32'h0F0F_0F0F); // full at head
    queue_cmd(piea_pkg::OP_ERASE,  piea_pkg::DEPTH - 1, 32'h0);         // last entry
    queue_cmd(piea_pkg::OP_ERASE,  0,                   32'h0);         // head
    queue_cmd(piea_pkg::OP_ERASE,  7,                   32'h0);         // middle

    // random: mostly well-formed positions, the bias swings so that the list
    // keeps running up to full and back down to empty
    ins_bias = 75;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 90 == 0) ins_bias = (ins_bias > 50) ? 25 : 75;
      if ($urandom_range(0, 99) < 12) begin
        queue_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 31), $urandom());
      end else begin
        op = ($urandom_range(0, 99) < ins_bias) ? piea_pkg::OP_INSERT : piea_pkg::OP_ERASE;
        if (op == piea_pkg::OP_INSERT)
          queue_cmd(op, $urandom_range(0, stim_len), pick_value());
        else
          queue_cmd(op, (stim_len == 0) ? 0 : $urandom_range(0, stim_len - 1), $urandom());
      end
    end
    n_items = pending_q.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_items) @(posedge clk_i);
    drain = 0;
    while (expected_q.size() != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_q.size());
      n_errors++;
    end
    repeat (8) @(posedge clk_i);

    $display("Covered %0d transactions (%0d inserts), %0d results checked, %0d errors.",
             n_accepted, n_inserts, n_results, n_errors);
    $display("Status seen: ok %0d, bad position %0d, full %0d, empty %0d.",
             status_hits[piea_pkg::ST_OK], status_hits[piea_pkg::ST_BAD_POS],
             status_hits[piea_pkg::ST_FULL], status_hits[piea_pkg::ST_EMPTY]);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("simulation failed");
    $finish;
  end

endmodule
